// ===== rtl/dgwu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the digitizer group word unpacker.
// No dependencies.
package dgwu_pkg;

   localparam int WordWidth    = 32;
   localparam int ValueWidth   = 30;
   localparam int IndexWidth   = 11;
   localparam int ChannelWidth = 4;
   localparam int KindWidth    = 2;
   localparam int PartialWidth = 8;
   localparam int WordsWidth   = 12;
   localparam int TrigWidth    = 9;
   localparam int SampleWidth  = 12;
   localparam int StartWidth   = 10;

   // Region of the frame; the code doubles as the result kind.
   typedef enum logic [KindWidth-1:0] {
      RegionHeader  = 2'd0,
      RegionChannel = 2'd1,
      RegionTrigger = 2'd2,
      RegionTag     = 2'd3
   } region_type;

   typedef enum logic [1:0] {
      Phase0 = 2'd0,
      Phase1 = 2'd1,
      Phase2 = 2'd2,
      Phase3 = 2'd3
   } phase_type;

   localparam logic [ChannelWidth-1:0] TriggerChannel = 4'd8;

   // One classified word, passed from the front to the back.
   typedef struct packed {
      region_type                region;
      phase_type                 phase;
      logic [IndexWidth-1:0]     sample_index;
      logic [PartialWidth-1:0]   partial;
      logic [WordWidth-1:0]      word;
   } record_type;

endpackage

// ===== rtl/dgwu_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts frame words, tracks the frame region and carry bits,
// and writes one classified record per word. Depends on dgwu_pkg.
module dgwu_front
   import dgwu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [WordWidth-1:0] req_word,
   input  logic       queue_full,
   output logic       full,
   output logic       rec_push,
   output record_type rec_data
);

   region_type              region_ff, region_in;
   phase_type               phase_ff, phase_in;
   logic [WordsWidth-1:0]   words_left_ff, words_left_in;
   logic [TrigWidth-1:0]    trig_left_ff, trig_left_in;
   logic [IndexWidth-1:0]   count_ff, count_in;
   logic [PartialWidth-1:0] partial_ff, partial_in;
   logic [WordsWidth-1:0]   words_dec;
   logic [TrigWidth-1:0]    trig_dec;
   logic                    accept;

   assign full     = queue_full;
   assign accept   = push && !queue_full;
   assign rec_push = accept;

   assign rec_data.region       = region_ff;
   assign rec_data.phase        = phase_ff;
   assign rec_data.sample_index = count_ff;
   assign rec_data.partial      = partial_ff;
   assign rec_data.word         = req_word;

   assign words_dec = words_left_ff - WordsWidth'(1);
   assign trig_dec  = trig_left_ff - TrigWidth'(1);

   always_comb begin
      region_in     = region_ff;
      phase_in      = phase_ff;
      words_left_in = words_left_ff;
      trig_left_in  = trig_left_ff;
      count_in      = count_ff;
      partial_in    = partial_ff;
      if (accept) begin
         unique case (region_ff)
            RegionHeader: begin
               words_left_in = req_word[11:0];
               trig_left_in  = req_word[20:12];
               phase_in      = Phase0;
               count_in      = '0;
               partial_in    = '0;
               if (req_word[11:0] != '0) begin
                  region_in = RegionChannel;
               end else if (req_word[20:12] != '0) begin
                  region_in = RegionTrigger;
               end else begin
                  region_in = RegionTag;
               end
            end
            RegionChannel: begin
               unique case (phase_ff)
                  Phase0: begin
                     partial_in = req_word[31:24];
                     phase_in   = Phase1;
                  end
                  Phase1: begin
                     partial_in = {4'd0, req_word[31:28]};
                     phase_in   = Phase2;
                  end
                  Phase2, Phase3: begin
                     partial_in = '0;
                     phase_in   = Phase0;
                     count_in   = count_ff + IndexWidth'(1);
                  end
               endcase
               words_left_in = words_dec;
               if (words_dec == '0) begin
                  phase_in   = Phase0;
                  count_in   = '0;
                  partial_in = '0;
                  region_in  = (trig_left_ff != '0) ? RegionTrigger : RegionTag;
               end
            end
            RegionTrigger: begin
               unique case (phase_ff)
                  Phase0: begin
                     partial_in = req_word[31:24];
                     count_in   = count_ff + IndexWidth'(2);
                     phase_in   = Phase1;
                  end
                  Phase1: begin
                     partial_in = {4'd0, req_word[31:28]};
                     count_in   = count_ff + IndexWidth'(3);
                     phase_in   = Phase2;
                  end
                  Phase2, Phase3: begin
                     partial_in = '0;
                     count_in   = count_ff + IndexWidth'(3);
                     phase_in   = Phase0;
                  end
               endcase
               trig_left_in = trig_dec;
               if (trig_dec == '0) begin
                  region_in  = RegionTag;
                  phase_in   = Phase0;
                  partial_in = '0;
               end
            end
            RegionTag: begin
               region_in     = RegionHeader;
               words_left_in = '0;
               trig_left_in  = '0;
               phase_in      = Phase0;
               count_in      = '0;
               partial_in    = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff     <= RegionHeader;
         phase_ff      <= Phase0;
         words_left_ff <= '0;
         trig_left_ff  <= '0;
         count_ff      <= '0;
         partial_ff    <= '0;
      end else begin
         region_ff     <= region_in;
         phase_ff      <= phase_in;
         words_left_ff <= words_left_in;
         trig_left_ff  <= trig_left_in;
         count_ff      <= count_in;
         partial_ff    <= partial_in;
      end
   end

endmodule

// ===== rtl/dgwu_queue.sv =====
`timescale 1ns / 1ps
// Two-entry record queue between front and back; head entry at a fixed place.
// Depends on dgwu_pkg.
module dgwu_queue
   import dgwu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  record_type wr_data,
   output logic       full,
   input  logic       rd_en,
   output logic       head_valid,
   output record_type head_data
);

   logic [1:0] count_ff, count_in;
   record_type head_ff, head_in;
   record_type tail_ff, tail_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = head_ff;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      priority if (wr_en && rd_en) begin
         if (count_ff == 2'd2) begin
            head_in = tail_ff;
            tail_in = wr_data;
         end else begin
            head_in = wr_data;
         end
      end else if (rd_en) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (wr_en) begin
         if (count_ff == 2'd0) begin
            head_in = wr_data;
         end else begin
            tail_in = wr_data;
         end
         count_in = count_ff + 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

// ===== rtl/dgwu_back.sv =====
`timescale 1ns / 1ps
// Back end: expands each record into one to three results, one per cycle while the
// registered output beat they go into is free or popped. Depends on dgwu_pkg.
module dgwu_back
   import dgwu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  record_type head_data,
   output logic       head_done,
   output logic       empty,
   input  logic       pop,
   output logic [KindWidth-1:0]    rsp_kind,
   output logic [ChannelWidth-1:0] rsp_channel,
   output logic [IndexWidth-1:0]   rsp_sample_index,
   output logic [ValueWidth-1:0]   rsp_value,
   output logic                    rsp_last_of_word,
   output logic                    rsp_end_of_event
);

   logic [1:0]              slot_ff, slot_in;
   logic                    out_valid_ff, out_valid_in;
   logic [KindWidth-1:0]    kind_ff;
   logic [ChannelWidth-1:0] channel_ff, channel_in;
   logic [IndexWidth-1:0]   index_ff, index_in;
   logic [ValueWidth-1:0]   value_ff, value_in;
   logic                    last_ff, eoe_ff, eoe_in;
   logic [1:0]              slot_last;
   logic                    is_last, fire;
   logic [ChannelWidth-1:0] chan_base;
   logic [SampleWidth-1:0]  sample;
   logic [WordWidth-1:0]    w;

   assign w = head_data.word;

   always_comb begin
      unique case (head_data.region)
         RegionHeader, RegionTag: slot_last = 2'd0;
         RegionChannel, RegionTrigger:
            slot_last = (head_data.phase == Phase0) ? 2'd1 : 2'd2;
      endcase
   end

   assign is_last   = (slot_ff == slot_last);
   assign fire      = head_valid && (!out_valid_ff || pop);
   assign head_done = fire && is_last;

   always_comb begin
      sample    = '0;
      chan_base = '0;
      unique case (head_data.phase)
         Phase0: begin
            chan_base = 4'd0;
            sample    = (slot_ff == 2'd0) ? w[11:0] : w[23:12];
         end
         Phase1: begin
            chan_base = 4'd2;
            unique case (slot_ff)
               2'd0:       sample = {w[3:0], head_data.partial};
               2'd1:       sample = w[15:4];
               2'd2, 2'd3: sample = w[27:16];
            endcase
         end
         Phase2, Phase3: begin
            chan_base = 4'd5;
            unique case (slot_ff)
               2'd0:       sample = {w[7:0], head_data.partial[3:0]};
               2'd1:       sample = w[19:8];
               2'd2, 2'd3: sample = w[31:20];
            endcase
         end
      endcase
   end

   always_comb begin
      channel_in = '0;
      index_in   = '0;
      value_in   = '0;
      eoe_in     = 1'b0;
      unique case (head_data.region)
         RegionHeader: begin
            value_in = ValueWidth'(w[30:21]);
         end
         RegionChannel: begin
            channel_in = chan_base + ChannelWidth'(slot_ff);
            index_in   = head_data.sample_index;
            value_in   = ValueWidth'(sample);
         end
         RegionTrigger: begin
            channel_in = TriggerChannel;
            index_in   = head_data.sample_index + IndexWidth'(slot_ff);
            value_in   = ValueWidth'(sample);
         end
         RegionTag: begin
            value_in = w[29:0];
            eoe_in   = 1'b1;
         end
      endcase
   end

   always_comb begin
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         slot_in      = is_last ? 2'd0 : slot_ff + 2'd1;
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
      if (fire) begin
         kind_ff    <= head_data.region;
         channel_ff <= channel_in;
         index_ff   <= index_in;
         value_ff   <= value_in;
         last_ff    <= is_last;
         eoe_ff     <= eoe_in;
      end
   end

   assign empty            = !out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_channel      = channel_ff;
   assign rsp_sample_index = index_ff;
   assign rsp_value        = value_ff;
   assign rsp_last_of_word = last_ff;
   assign rsp_end_of_event = eoe_ff;

endmodule

// ===== rtl/digitizer_group_word_unpacker.sv =====
`timescale 1ns / 1ps
// Digitizer group word unpacker: front classifier, record queue, result expander.
// A word's record is registered in the queue head, then each result in the output register.
// One result per cycle out of the back end while its output beat is free or popped, so three
// results per three-sample word, one per header or time tag word; the slot counter sets it.
// Reset (synchronous, active high) returns to awaiting a header and empties the queue.
module digitizer_group_word_unpacker
   import dgwu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [WordWidth-1:0]    req_word,
   output logic                    empty,
   input  logic                    pop,
   output logic [KindWidth-1:0]    rsp_kind,
   output logic [ChannelWidth-1:0] rsp_channel,
   output logic [IndexWidth-1:0]   rsp_sample_index,
   output logic [ValueWidth-1:0]   rsp_value,
   output logic                    rsp_last_of_word,
   output logic                    rsp_end_of_event
);

   logic       queue_full;
   logic       rec_push;
   record_type rec_data;
   logic       head_valid;
   record_type head_data;
   logic       head_done;

   dgwu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_word   (req_word),
      .queue_full (queue_full),
      .full       (full),
      .rec_push   (rec_push),
      .rec_data   (rec_data)
   );

   dgwu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (rec_push),
      .wr_data    (rec_data),
      .full       (queue_full),
      .rd_en      (head_done),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   dgwu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .head_done        (head_done),
      .empty            (empty),
      .pop              (pop),
      .rsp_kind         (rsp_kind),
      .rsp_channel      (rsp_channel),
      .rsp_sample_index (rsp_sample_index),
      .rsp_value        (rsp_value),
      .rsp_last_of_word (rsp_last_of_word),
      .rsp_end_of_event (rsp_end_of_event)
   );

endmodule
